// File: rtl/agrs_pkg.sv
// Shared types and constants of the alignment gap run scanner.
`default_nettype none
package agrs_pkg;

  localparam int MAX_COLUMNS_DEF = 65536;

  localparam int SEQ_W     = 10;
  localparam int COL_OUT_W = 16;
  localparam int SEQ_LEN_W = 17;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int FIFO_DEPTH = 4;

  // symbol classes on the input
  localparam logic [1:0] SYM_RESIDUE = 2'd0;
  localparam logic [1:0] SYM_GAP     = 2'd1;
  localparam logic [1:0] SYM_UNK     = 2'd2;

  // record kinds on the output
  localparam logic [1:0] RUN_INDEL   = 2'd0;
  localparam logic [1:0] RUN_UNKNOWN = 2'd1;
  localparam logic [1:0] RUN_EDGE    = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_SEQ_LENGTH = 1'b0;
  localparam logic REG_OMIT_EDGE  = 1'b1;

  typedef struct packed {
    logic [1:0]           run_kind;
    logic [SEQ_W-1:0]     run_seq;
    logic [COL_OUT_W-1:0] run_first;
    logic [COL_OUT_W-1:0] run_final;
    logic [COL_OUT_W-1:0] run_first_ungapped;
    logic                 is_last;
  } rec_t;

  // records produced by one processed symbol
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage
`default_nettype wire

// File: rtl/agrs_if.sv
// Valid/ready channel interfaces for symbols in and run records out.
`default_nettype none
interface agrs_in_if;
  import agrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       symbol_kind;
  logic [SEQ_W-1:0] seq_id;
  modport source (output valid, symbol_kind, seq_id, input ready);
  modport sink   (input valid, symbol_kind, seq_id, output ready);
endinterface

interface agrs_out_if;
  import agrs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           run_kind;
  logic [SEQ_W-1:0]     run_seq;
  logic [COL_OUT_W-1:0] run_first;
  logic [COL_OUT_W-1:0] run_final;
  logic [COL_OUT_W-1:0] run_first_ungapped;
  logic                 is_last;
  modport source (output valid, run_kind, run_seq, run_first, run_final,
                  run_first_ungapped, is_last, input ready);
  modport sink   (input valid, run_kind, run_seq, run_first, run_final,
                  run_first_ungapped, is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/agrs_step.sv
// Per-sequence scan state and run record generation for one symbol.
`default_nettype none
module agrs_step #(
  parameter int MAX_COLUMNS = agrs_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                fire_i,
  input  wire logic [1:0]                          sym_i,
  input  wire logic [agrs_pkg::SEQ_W-1:0]          sid_i,
  input  wire logic [$clog2(MAX_COLUMNS)-1:0]      last_col_i,
  input  wire logic                                omit_i,
  output agrs_pkg::push_t                          push_o
);
  import agrs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);

  typedef enum logic [1:0] {
    OPEN_NONE = 2'd0,
    OPEN_GAP  = 2'd1,
    OPEN_UNK  = 2'd2
  } open_e;

  logic [CW-1:0]    column_q, column_d;
  logic [CW-1:0]    gaps_q, gaps_d;
  open_e            open_kind_q, open_kind_d;
  logic [CW-1:0]    open_start_q, open_start_d;
  logic [CW-1:0]    open_fu_q, open_fu_d;
  logic [SEQ_W-1:0] open_seq_q, open_seq_d;

  open_e         kind, mid_kind, new_kind;
  logic          at_last, close_old, start_new, close_end;
  logic [CW-1:0] new_start, new_fu, gaps_inc;
  logic [SEQ_W-1:0] new_seq;
  rec_t          rec_a, rec_b;

  function automatic rec_t make_rec(open_e k, logic [CW-1:0] first, logic [CW-1:0] fin,
                                    logic [CW-1:0] fu, logic [SEQ_W-1:0] sid,
                                    logic omit, logic [CW-1:0] lastc);
    rec_t r;
    if (k == OPEN_UNK) begin
      r.run_kind = RUN_UNKNOWN;
    end else if (omit && (fu == '0 || fin >= lastc)) begin
      r.run_kind = RUN_EDGE;
    end else begin
      r.run_kind = RUN_INDEL;
    end
    r.run_seq            = sid;
    r.run_first          = COL_OUT_W'(first);
    r.run_final          = COL_OUT_W'(fin);
    r.run_first_ungapped = COL_OUT_W'(fu);
    r.is_last            = 1'b0;
    return r;
  endfunction

  always_comb begin
    case (sym_i)
      SYM_GAP: kind = OPEN_GAP;
      SYM_UNK: kind = OPEN_UNK;
      default: kind = OPEN_NONE;
    endcase

    at_last   = column_q >= last_col_i;
    close_old = (open_kind_q != OPEN_NONE) && (open_kind_q != kind);
    rec_a     = make_rec(open_kind_q, open_start_q, column_q - CW'(1), open_fu_q,
                         open_seq_q, omit_i, last_col_i);

    mid_kind  = close_old ? OPEN_NONE : open_kind_q;
    start_new = (kind != OPEN_NONE) && (mid_kind == OPEN_NONE);
    new_kind  = start_new ? kind : mid_kind;
    new_start = start_new ? column_q : open_start_q;
    new_fu    = start_new ? (column_q - gaps_q) : open_fu_q;
    new_seq   = start_new ? sid_i : open_seq_q;
    gaps_inc  = gaps_q + ((kind == OPEN_GAP) ? CW'(1) : CW'(0));

    close_end = at_last && (new_kind != OPEN_NONE);
    rec_b     = make_rec(new_kind, new_start, column_q, new_fu, new_seq, omit_i, last_col_i);

    push_o.cnt          = fire_i ? (2'(close_old) + 2'(close_end)) : 2'd0;
    push_o.rec0         = close_old ? rec_a : rec_b;
    push_o.rec0.is_last = !(close_old && close_end);
    push_o.rec1         = rec_b;
    push_o.rec1.is_last = 1'b1;

    if (at_last) begin
      // sequence ends: back to the reset picture
      column_d     = '0;
      gaps_d       = '0;
      open_kind_d  = OPEN_NONE;
      open_start_d = '0;
      open_fu_d    = '0;
      open_seq_d   = '0;
    end else begin
      column_d     = column_q + CW'(1);
      gaps_d       = gaps_inc;
      open_kind_d  = new_kind;
      open_start_d = new_start;
      open_fu_d    = new_fu;
      open_seq_d   = new_seq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      gaps_q       <= '0;
      open_kind_q  <= OPEN_NONE;
      open_start_q <= '0;
      open_fu_q    <= '0;
      open_seq_q   <= '0;
    end else if (fire_i) begin
      column_q     <= column_d;
      gaps_q       <= gaps_d;
      open_kind_q  <= open_kind_d;
      open_start_q <= open_start_d;
      open_fu_q    <= open_fu_d;
      open_seq_q   <= open_seq_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/agrs_rec_fifo.sv
// Small record queue: up to two records in per cycle, one out.
`default_nettype none
module agrs_rec_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire agrs_pkg::push_t push_i,
  output logic                 room2_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output agrs_pkg::rec_t       rec_o
);
  import agrs_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  rec_t          entries_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;
  logic          pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign rec_o   = entries_q[rd_ptr_q];
  assign room2_o = count_q <= (PW+1)'(FIFO_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.cnt == 2'd2) begin
      entries_q[wr_ptr_q + PW'(1)] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      count_q  <= count_q + (PW+1)'(push_i.cnt) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/alignment_gap_run_scanner.sv
// Alignment gap run scanner: top level with input register, APB registers and record queue.
// Path: an accepted symbol is held in the input register, scanned once the record queue
// has room for two, and its records written to the queue, behind any still queued there.
// Throughput: one symbol per cycle while the queue has room for two records; a symbol that
// closes two runs takes two output beats, set by the single-beat port and four-entry queue.
// Reset: scan state cleared, seq_length reads 1, omit_edge_gaps 0, queue empty.
`default_nettype none
module alignment_gap_run_scanner #(
  parameter int MAX_COLUMNS = agrs_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  agrs_in_if.sink                            in_i,
  agrs_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [agrs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [agrs_pkg::APB_DW-1:0]   pwdata,
  output logic      [agrs_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);
  import agrs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int LW = (CW + 1 > SEQ_LEN_W) ? CW + 1 : SEQ_LEN_W;

  // configuration
  logic [SEQ_LEN_W-1:0] seq_length_q;
  logic                 omit_q;
  logic [CW-1:0]        last_col_q, last_col_d;
  logic [LW-1:0]        len_ext;
  logic                 wr_en, reg_idx;

  // input register
  logic             in_valid_q;
  logic [1:0]       sym_q;
  logic [SEQ_W-1:0] sid_q;
  logic             fire, room2, in_take;

  push_t push;
  rec_t  head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // last column index after clamping the length to 1..MAX_COLUMNS
  always_comb begin
    len_ext = LW'(pwdata[SEQ_LEN_W-1:0]);
    if (len_ext == '0) begin
      last_col_d = '0;
    end else if (len_ext > LW'(MAX_COLUMNS)) begin
      last_col_d = CW'(MAX_COLUMNS - 1);
    end else begin
      last_col_d = CW'(len_ext - LW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q <= SEQ_LEN_W'(1);
      omit_q       <= 1'b0;
      last_col_q   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SEQ_LENGTH: begin
          seq_length_q <= pwdata[SEQ_LEN_W-1:0];
          last_col_q   <= last_col_d;
        end
        REG_OMIT_EDGE: omit_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEQ_LENGTH: prdata = APB_DW'(seq_length_q);
      REG_OMIT_EDGE:  prdata = APB_DW'(omit_q);
      default:        prdata = '0;
    endcase
  end

  // scan only when the queue can take two records
  assign fire       = in_valid_q && room2;
  assign in_i.ready = !in_valid_q || fire;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sym_q <= in_i.symbol_kind;
      sid_q <= in_i.seq_id;
    end
  end

  agrs_step #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .sym_i      (sym_q),
    .sid_i      (sid_q),
    .last_col_i (last_col_q),
    .omit_i     (omit_q),
    .push_o     (push)
  );

  agrs_rec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rec_o   (head)
  );

  assign out_o.run_kind           = head.run_kind;
  assign out_o.run_seq            = head.run_seq;
  assign out_o.run_first          = head.run_first;
  assign out_o.run_final          = head.run_final;
  assign out_o.run_first_ungapped = head.run_first_ungapped;
  assign out_o.is_last            = head.is_last;

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the alignment gap run scanner.
`timescale 1ns / 100ps
module tb;
  import agrs_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_COLS    = 256;

  // class code 3 is not defined and scans as a residue
  localparam logic [1:0] SYM_UNDEF = 2'd3;

  typedef enum logic [1:0] {OPEN_NONE, OPEN_GAP, OPEN_UNK} open_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  agrs_in_if  sym_if ();
  agrs_out_if run_if ();

  alignment_gap_run_scanner u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (sym_if),
    .out_o   (run_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scanner state as predicted, plus register copies
  logic [SEQ_LEN_W-1:0] cfg_len;
  logic                 cfg_omit;
  int unsigned          col;
  int unsigned          gaps_seen;
  int unsigned          open_first;
  int unsigned          open_ungapped;
  open_e                open_kind;
  logic [SEQ_W-1:0]     open_seq;

  rec_t        due_runs[$];
  int unsigned mismatches;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_left;

  function automatic int unsigned span();
    int unsigned n;
    n = cfg_len;
    if (n == 0) n = 1;
    if (n > MAX_COLUMNS_DEF) n = MAX_COLUMNS_DEF;
    return n;
  endfunction

  function automatic void clear_seq();
    col           = 0;
    gaps_seen     = 0;
    open_kind     = OPEN_NONE;
    open_first    = 0;
    open_ungapped = 0;
    open_seq      = '0;
  endfunction

  function automatic rec_t close_run(int unsigned final_col);
    rec_t r;
    if (open_kind == OPEN_UNK) begin
      r.run_kind = RUN_UNKNOWN;
    end else if (cfg_omit && (open_ungapped == 0 || final_col >= span() - 1)) begin
      r.run_kind = RUN_EDGE;
    end else begin
      r.run_kind = RUN_INDEL;
    end
    r.run_seq            = open_seq;
    r.run_first          = COL_OUT_W'(open_first);
    r.run_final          = COL_OUT_W'(final_col);
    r.run_first_ungapped = COL_OUT_W'(open_ungapped);
    r.is_last            = 1'b0;
    return r;
  endfunction

  // advance the scan by one symbol and queue the records it closes
  function automatic void scan_symbol(logic [1:0] sym, logic [SEQ_W-1:0] sid);
    rec_t  recs[$];
    open_e k;
    bit    at_end;
    at_end = col >= span() - 1;
    k = (sym == SYM_GAP) ? OPEN_GAP : (sym == SYM_UNK) ? OPEN_UNK : OPEN_NONE;
    if (open_kind != OPEN_NONE && open_kind != k) begin
      recs = {recs, close_run(col - 1)};
      open_kind = OPEN_NONE;
    end
    if (k != OPEN_NONE && open_kind == OPEN_NONE) begin
      open_kind     = k;
      open_first    = col;
      open_ungapped = col - gaps_seen;
      open_seq      = sid;
    end
    if (k == OPEN_GAP) gaps_seen++;
    if (at_end) begin
      if (open_kind != OPEN_NONE) recs = {recs, close_run(col)};
      clear_seq();
    end else begin
      col++;
    end
    if (recs.size() > 0) recs[recs.size()-1].is_last = 1'b1;
    foreach (recs[i]) due_runs = {due_runs, recs[i]};
  endfunction

  task automatic push_symbol(logic [1:0] sym, logic [SEQ_W-1:0] sid);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      sym_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sym_if.valid       <= 1'b1;
    sym_if.symbol_kind <= sym;
    sym_if.seq_id      <= sid;
    @(posedge clk_i);
    while (!sym_if.ready) @(posedge clk_i);
    scan_symbol(sym, sid);
  endtask

  // stop sending, let every record out, then give the pipeline time to empty
  task automatic settle();
    @(negedge clk_i);
    sym_if.valid <= 1'b0;
    while (due_runs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write a register, then read it back
  task automatic write_reg(logic idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_SEQ_LENGTH) cfg_len = value[SEQ_LEN_W-1:0];
    else cfg_omit = value[0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    want = (idx == REG_SEQ_LENGTH) ? APB_DW'(cfg_len) : APB_DW'(cfg_omit);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %0h, expected %0h", idx, prdata, want);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one sequence with runs of random kind, some stray ids and undefined codes
  task automatic send_sequence(int unsigned n);
    logic [SEQ_W-1:0] sid;
    logic [1:0]       cur;
    logic [1:0]       sym;
    sid = SEQ_W'($urandom_range(0, 1023));
    cur = 2'($urandom_range(0, 2));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40) cur = 2'($urandom_range(0, 2));
      sym = ($urandom_range(99) < 4) ? SYM_UNDEF : cur;
      push_symbol(sym, ($urandom_range(99) < 5) ? SEQ_W'($urandom_range(0, 1023)) : sid);
    end
  endtask

  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // edge runs at both ends, stray id, two records on the last column
    write_reg(REG_SEQ_LENGTH, 32'd6);
    write_reg(REG_OMIT_EDGE, 32'd1);
    push_symbol(SYM_GAP, 10'd1023);
    push_symbol(SYM_GAP, 10'd0);
    push_symbol(SYM_RESIDUE, 10'd1023);
    push_symbol(SYM_UNK, 10'd1023);
    push_symbol(SYM_GAP, 10'd1023);
    push_symbol(SYM_UNK, 10'd1023);
    push_symbol(SYM_UNDEF, 10'd0);
    push_symbol(SYM_RESIDUE, 10'd0);
    push_symbol(SYM_UNDEF, 10'd0);
    push_symbol(SYM_RESIDUE, 10'd0);
    push_symbol(SYM_GAP, 10'd0);
    push_symbol(SYM_GAP, 10'd0);
    settle();
    // zero length behaves as one column per sequence
    write_reg(REG_SEQ_LENGTH, 32'd0);
    write_reg(REG_OMIT_EDGE, 32'd0);
    push_symbol(SYM_GAP, 10'd512);
    push_symbol(SYM_UNK, 10'd1);
    push_symbol(SYM_RESIDUE, 10'd1023);
    push_symbol(SYM_UNDEF, 10'd0);
    settle();
    // oversized length clamps; then shrink it mid-sequence
    write_reg(REG_SEQ_LENGTH, 32'h1FFFF);
    push_symbol(SYM_UNK, 10'd5);
    push_symbol(SYM_UNK, 10'd5);
    push_symbol(SYM_GAP, 10'd5);
    settle();
    write_reg(REG_SEQ_LENGTH, 32'd2);
    push_symbol(SYM_GAP, 10'd5);
    push_symbol(SYM_RESIDUE, 10'd5);
    settle();
  endtask

  // receiver holds off while runs keep closing, so the record queue backs up
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_reg(REG_SEQ_LENGTH, 32'd3);
    write_reg(REG_OMIT_EDGE, 32'd1);
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 150; i++)
      push_symbol(2'($urandom_range(1, 2)), SEQ_W'($urandom_range(0, 1023)));
    settle();
  endtask

  task automatic test_random(int unsigned src_pct, int unsigned snk_pct);
    int unsigned r;
    int unsigned done;
    int unsigned n;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    r = $urandom_range(99);
    if (r < 80) n = $urandom_range(1, 12);
    else if (r < 90) n = $urandom_range(13, 64);
    else if (r < 95) n = 0;
    else n = $urandom_range(100, 400);
    write_reg(REG_SEQ_LENGTH, n);
    write_reg(REG_OMIT_EDGE, $urandom_range(0, 1));
    done = 0;
    while (done < RANDOM_ITEMS) begin
      n = span();
      send_sequence(n);
      done += n;
    end
    settle();
  endtask

  // one longer sequence, mostly residues, with gaps at both ends
  task automatic test_long_sequence();
    int unsigned r;
    logic [1:0]  sym;
    logic [SEQ_W-1:0] sid;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_reg(REG_SEQ_LENGTH, 32'(LONG_COLS));
    write_reg(REG_OMIT_EDGE, 32'd1);
    sid = SEQ_W'($urandom_range(0, 1023));
    for (int unsigned c = 0; c < LONG_COLS; c++) begin
      r = $urandom_range(99);
      sym = (r < 94) ? SYM_RESIDUE : (r < 97) ? SYM_GAP : SYM_UNK;
      if (c == 0 || c == LONG_COLS - 1) sym = SYM_GAP;
      push_symbol(sym, sid);
    end
    settle();
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      run_if.ready <= 1'b0;
      hold_left--;
    end else begin
      run_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_runs
    rec_t got;
    rec_t want;
    if (run_if.valid && run_if.ready) begin
      got.run_kind           = run_if.run_kind;
      got.run_seq            = run_if.run_seq;
      got.run_first          = run_if.run_first;
      got.run_final          = run_if.run_final;
      got.run_first_ungapped = run_if.run_first_ungapped;
      got.is_last            = run_if.is_last;
      if (due_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("record beat with nothing expected: %p", got);
      end else begin
        want = due_runs.pop_front();
        if (got.run_kind !== want.run_kind || got.run_seq !== want.run_seq ||
            got.run_first !== want.run_first || got.run_final !== want.run_final ||
            got.run_first_ungapped !== want.run_first_ungapped ||
            got.is_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch (exp/got): kind %0d/%0d seq %0d/%0d first %0d/%0d",
                     want.run_kind, got.run_kind, want.run_seq, got.run_seq,
                     want.run_first, got.run_first,
                     "  final %0d/%0d ungapped %0d/%0d last %0b/%0b",
                     want.run_final, got.run_final, want.run_first_ungapped,
                     got.run_first_ungapped, want.is_last, got.is_last);
        end
      end
    end
  end

  // ends the run once no beat has moved on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((sym_if.valid && sym_if.ready) || (run_if.valid && run_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    sym_if.valid       = 1'b0;
    sym_if.symbol_kind = SYM_RESIDUE;
    sym_if.seq_id      = '0;
    run_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cfg_len            = 1;
    cfg_omit           = 1'b0;
    mismatches         = 0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    hold_left          = 0;
    clear_seq();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random(0, 0);
    test_random(55, 0);
    test_random(0, 55);
    test_random(28, 28);
    test_long_sequence();

    mismatches += due_runs.size();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: alignment_gap_run_scanner.f
rtl/agrs_pkg.sv
rtl/agrs_if.sv
rtl/agrs_step.sv
rtl/agrs_rec_fifo.sv
rtl/alignment_gap_run_scanner.sv
verif/tb.sv
